// ===== hw/rtl/rbnp_pkg.sv =====
// Package: widths, item types and state codes for the ray box picker.
package rbnp_pkg;

  localparam int BOX_SLOTS     = 16;
  localparam int SLOT_W        = 4;
  localparam int COUNT_W       = 5;
  localparam int VAL_W         = 32;
  localparam int FRACTION_BITS = 16;
  localparam int DIFF_W        = VAL_W + 1;
  localparam int NUM_W         = DIFF_W + FRACTION_BITS;
  localparam int T_W           = NUM_W + 1;
  localparam int DCNT_W        = $clog2(NUM_W);
  localparam int DIST_W        = 31;
  localparam int ADDR_W        = 3;

  localparam logic REG_BOX_COUNT = 1'b0;
  localparam logic CMD_WRITE     = 1'b0;
  localparam logic CMD_PICK      = 1'b1;

  localparam logic signed [T_W-1:0] T_INFINITE = {1'b0, {(T_W-1){1'b1}}};
  localparam logic signed [T_W-1:0] T_DIST_MAX = T_W'({DIST_W{1'b1}});

  typedef struct packed {
    logic                    cmd;
    logic [SLOT_W-1:0]       box_slot;
    logic signed [VAL_W-1:0] origin_or_min_x;
    logic signed [VAL_W-1:0] origin_or_min_y;
    logic signed [VAL_W-1:0] origin_or_min_z;
    logic signed [VAL_W-1:0] dir_or_max_x;
    logic signed [VAL_W-1:0] dir_or_max_y;
    logic signed [VAL_W-1:0] dir_or_max_z;
  } in_item_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic [DIST_W-1:0] hit_distance;
    logic              selection_changed;
  } out_item_t;

  typedef struct packed {
    logic                    is_pick;
    logic [SLOT_W-1:0]       slot;
    logic [2:0][VAL_W-1:0]   lo;
    logic [2:0][VAL_W-1:0]   hi;
  } queue_entry_t;

  typedef struct packed {
    logic [2:0][VAL_W-1:0] mn;
    logic [2:0][VAL_W-1:0] mx;
  } box_row_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_AXIS,
    B_DIV_LO,
    B_DIV_HI,
    B_BOX_END,
    B_RESULT
  } back_state_t;

endpackage

// ===== hw/rtl/rbnp_front.sv =====
// Front queue: accepts items, classifies them and holds them for the back end.
module rbnp_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  rbnp_pkg::in_item_t      in_item,
  output logic                    entry_valid,
  output rbnp_pkg::queue_entry_t  entry,
  input  logic                    pop
);

  rbnp_pkg::queue_entry_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  rbnp_pkg::queue_entry_t classified;

  always_comb begin
    classified.is_pick = (in_item.cmd == rbnp_pkg::CMD_PICK);
    classified.slot    = in_item.box_slot;
    classified.lo      = {in_item.origin_or_min_z, in_item.origin_or_min_y,
                          in_item.origin_or_min_x};
    classified.hi      = {in_item.dir_or_max_z, in_item.dir_or_max_y,
                          in_item.dir_or_max_x};
  end

  assign in_stall    = count[1];
  assign push        = in_valid && !in_stall;
  assign entry_valid = (count != 2'd0);
  assign entry       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/rbnp_div.sv =====
// Serial signed divider: one quotient bit per cycle, truncated toward zero.
module rbnp_div (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [rbnp_pkg::NUM_W-1:0]     num,
  input  logic signed [rbnp_pkg::VAL_W-1:0]     den,
  output logic                                  done,
  output logic signed [rbnp_pkg::T_W-1:0]       quot
);

  logic                              busy;
  logic [rbnp_pkg::DCNT_W-1:0]       cnt;
  logic [rbnp_pkg::NUM_W-1:0]        acc;
  logic [rbnp_pkg::VAL_W-1:0]        rem;
  logic [rbnp_pkg::VAL_W-1:0]        dvs;
  logic                              neg;
  logic [rbnp_pkg::NUM_W-1:0]        num_mag;
  logic [rbnp_pkg::VAL_W-1:0]        den_mag;
  logic [rbnp_pkg::VAL_W:0]          r_sh;
  logic                              qbit;
  logic [rbnp_pkg::VAL_W:0]          r_sub;

  assign num_mag = num[rbnp_pkg::NUM_W-1] ? rbnp_pkg::NUM_W'(-num) : num;
  assign den_mag = den[rbnp_pkg::VAL_W-1] ? rbnp_pkg::VAL_W'(-den) : den;
  assign r_sh    = {rem, acc[rbnp_pkg::NUM_W-1]};
  assign qbit    = (r_sh >= {1'b0, dvs});
  assign r_sub   = r_sh - {1'b0, dvs};
  assign quot    = neg ? -$signed({1'b0, acc}) : $signed({1'b0, acc});

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= num_mag;
      rem <= '0;
      dvs <= den_mag;
      neg <= num[rbnp_pkg::NUM_W-1] ^ den[rbnp_pkg::VAL_W-1];
    end else if (busy) begin
      acc <= {acc[rbnp_pkg::NUM_W-2:0], qbit};
      rem <= qbit ? r_sub[rbnp_pkg::VAL_W-1:0] : r_sh[rbnp_pkg::VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == rbnp_pkg::DCNT_W'(rbnp_pkg::NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/rbnp_back.sv =====
// Back end: box table, slab test sequencer, nearest-hit selection and result register.
module rbnp_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               entry_valid,
  input  rbnp_pkg::queue_entry_t             entry,
  output logic                               pop,
  input  logic [rbnp_pkg::COUNT_W-1:0]       box_count,
  output logic                               out_valid,
  input  logic                               out_stall,
  output rbnp_pkg::out_item_t                out_item
);

  rbnp_pkg::back_state_t state, state_next;

  rbnp_pkg::box_row_t mem [rbnp_pkg::BOX_SLOTS];
  rbnp_pkg::box_row_t rd_row;

  logic [2:0][rbnp_pkg::VAL_W-1:0] ray_o;
  logic [2:0][rbnp_pkg::VAL_W-1:0] ray_d;
  logic [rbnp_pkg::COUNT_W-1:0]    n;
  logic [rbnp_pkg::SLOT_W-1:0]     idx;
  logic [1:0]                      ax;
  logic                            alive;
  logic signed [rbnp_pkg::T_W-1:0] tmin;
  logic signed [rbnp_pkg::T_W-1:0] tmax;
  logic signed [rbnp_pkg::T_W-1:0] t1;
  logic                            found;
  logic signed [rbnp_pkg::T_W-1:0] best_t;
  logic [rbnp_pkg::SLOT_W-1:0]     best_slot;
  logic                            sel_valid;
  logic [rbnp_pkg::SLOT_W-1:0]     sel_slot;

  logic                            div_start;
  logic                            div_done;
  logic signed [rbnp_pkg::NUM_W-1:0] div_num;
  logic signed [rbnp_pkg::T_W-1:0] div_quot;
  logic                            out_load;
  logic                            ax_last;
  logic                            last_box;

  logic signed [rbnp_pkg::VAL_W-1:0]  cur_o;
  logic signed [rbnp_pkg::VAL_W-1:0]  cur_d;
  logic signed [rbnp_pkg::VAL_W-1:0]  cur_mn;
  logic signed [rbnp_pkg::VAL_W-1:0]  cur_mx;
  logic signed [rbnp_pkg::DIFF_W-1:0] diff_lo;
  logic signed [rbnp_pkg::DIFF_W-1:0] diff_hi;
  logic                               slab_inside;
  logic signed [rbnp_pkg::T_W-1:0]    s_lo;
  logic signed [rbnp_pkg::T_W-1:0]    s_hi;
  logic signed [rbnp_pkg::T_W-1:0]    tmin_new;
  logic signed [rbnp_pkg::T_W-1:0]    tmax_new;
  logic                               box_hit;
  logic                               better;
  logic [rbnp_pkg::COUNT_W-1:0]       n_clip;
  logic [rbnp_pkg::DIST_W-1:0]        hit_dist;
  logic                               changed;

  assign ax_last  = (ax == 2'd3);
  assign cur_o    = $signed(ray_o[ax]);
  assign cur_d    = $signed(ray_d[ax]);
  assign cur_mn   = $signed(rd_row.mn[ax]);
  assign cur_mx   = $signed(rd_row.mx[ax]);
  assign diff_lo  = rbnp_pkg::DIFF_W'(cur_mn) - rbnp_pkg::DIFF_W'(cur_o);
  assign diff_hi  = rbnp_pkg::DIFF_W'(cur_mx) - rbnp_pkg::DIFF_W'(cur_o);
  assign slab_inside = (cur_o >= cur_mn) && (cur_o <= cur_mx);
  assign div_num  = (state == rbnp_pkg::B_DIV_LO)
                  ? {diff_hi, {rbnp_pkg::FRACTION_BITS{1'b0}}}
                  : {diff_lo, {rbnp_pkg::FRACTION_BITS{1'b0}}};
  assign s_lo     = (t1 > div_quot) ? div_quot : t1;
  assign s_hi     = (t1 > div_quot) ? t1 : div_quot;
  assign tmin_new = (s_lo > tmin) ? s_lo : tmin;
  assign tmax_new = (s_hi < tmax) ? s_hi : tmax;
  assign box_hit  = alive && (tmax >= 0);
  assign better   = box_hit && (!found || (tmin < best_t));
  assign last_box = (({1'b0, idx} + 1'b1) == n);
  assign n_clip   = (box_count > rbnp_pkg::COUNT_W'(rbnp_pkg::BOX_SLOTS))
                  ? rbnp_pkg::COUNT_W'(rbnp_pkg::BOX_SLOTS) : box_count;
  assign hit_dist = found ? ((best_t > rbnp_pkg::T_DIST_MAX)
                    ? {rbnp_pkg::DIST_W{1'b1}} : best_t[rbnp_pkg::DIST_W-1:0]) : '0;
  assign changed  = found ? (!sel_valid || (sel_slot != best_slot)) : sel_valid;

  rbnp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (cur_d),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      rbnp_pkg::B_IDLE: begin
        if (entry_valid && entry.is_pick) begin
          state_next = (n_clip == '0) ? rbnp_pkg::B_RESULT : rbnp_pkg::B_READ;
        end
      end
      rbnp_pkg::B_READ: state_next = rbnp_pkg::B_AXIS;
      rbnp_pkg::B_AXIS: begin
        if (ax_last || !alive) begin
          state_next = rbnp_pkg::B_BOX_END;
        end else if (cur_d != '0) begin
          state_next = rbnp_pkg::B_DIV_LO;
        end
      end
      rbnp_pkg::B_DIV_LO: begin
        if (div_done) begin
          state_next = rbnp_pkg::B_DIV_HI;
        end
      end
      rbnp_pkg::B_DIV_HI: begin
        if (div_done) begin
          state_next = rbnp_pkg::B_AXIS;
        end
      end
      rbnp_pkg::B_BOX_END: begin
        state_next = last_box ? rbnp_pkg::B_RESULT : rbnp_pkg::B_READ;
      end
      rbnp_pkg::B_RESULT: begin
        if (!out_valid || !out_stall) begin
          state_next = rbnp_pkg::B_IDLE;
        end
      end
      default: state_next = rbnp_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      rbnp_pkg::B_IDLE:   pop = entry_valid;
      rbnp_pkg::B_AXIS:   div_start = !ax_last && alive && (cur_d != '0);
      rbnp_pkg::B_DIV_LO: div_start = div_done;
      rbnp_pkg::B_RESULT: out_load = !out_valid || !out_stall;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == rbnp_pkg::B_IDLE && entry_valid && !entry.is_pick
        && ({1'b0, entry.slot} < (rbnp_pkg::SLOT_W+1)'(rbnp_pkg::BOX_SLOTS))) begin
      mem[entry.slot] <= '{mn: entry.lo, mx: entry.hi};
    end
    rd_row <= mem[idx];
  end

  always_ff @(posedge clk) begin
    unique case (state)
      rbnp_pkg::B_IDLE: begin
        ray_o <= entry.lo;
        ray_d <= entry.hi;
        n     <= n_clip;
        idx   <= '0;
        found <= 1'b0;
        best_t <= rbnp_pkg::T_INFINITE;
        best_slot <= '0;
      end
      rbnp_pkg::B_READ: begin
        ax    <= 2'd0;
        alive <= 1'b1;
        tmin  <= '0;
        tmax  <= rbnp_pkg::T_INFINITE;
      end
      rbnp_pkg::B_AXIS: begin
        if (!ax_last && alive && cur_d == '0) begin
          alive <= slab_inside;
          ax    <= ax + 2'd1;
        end
      end
      rbnp_pkg::B_DIV_LO: begin
        if (div_done) begin
          t1 <= div_quot;
        end
      end
      rbnp_pkg::B_DIV_HI: begin
        if (div_done) begin
          tmin  <= tmin_new;
          tmax  <= tmax_new;
          alive <= (tmin_new <= tmax_new);
          ax    <= ax + 2'd1;
        end
      end
      rbnp_pkg::B_BOX_END: begin
        if (better) begin
          found     <= 1'b1;
          best_t    <= tmin;
          best_slot <= idx;
        end
        idx <= idx + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item.hit               <= found;
      out_item.hit_slot          <= found ? best_slot : '0;
      out_item.hit_distance      <= hit_dist;
      out_item.selection_changed <= changed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rbnp_pkg::B_IDLE;
      out_valid <= 1'b0;
      sel_valid <= 1'b0;
      sel_slot  <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
        sel_valid <= found;
        sel_slot  <= found ? best_slot : '0;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/ray_box_nearest_pick.sv =====
// Top level of the ray box picker: front queue, back end and configuration port.
// A box write is taken from the queue while the back end is idle and produces no result.
// A pick runs the slab test over slots 0 to box_count-1 (at most 16), one box at a time,
// through a single serial divider that yields one quotient bit per cycle. Each box passes
// through a row read, one step per axis tested, an axis wrap-up and a box compare, and
// each axis whose direction is nonzero adds two divisions; a pick with box_count 0 goes
// straight to the result. A two-item queue keeps accepting items while the back end
// works, until it holds two, and the result register holds a finished result while the
// next pick runs.
module ray_box_nearest_pick (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  rbnp_pkg::in_item_t                in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output rbnp_pkg::out_item_t               out_item,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rbnp_pkg::ADDR_W-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic [rbnp_pkg::COUNT_W-1:0] box_count;
  logic                         entry_valid;
  rbnp_pkg::queue_entry_t       entry;
  logic                         pop;
  logic                         reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == rbnp_pkg::REG_BOX_COUNT);
  assign prdata  = reg_sel ? {{(32-rbnp_pkg::COUNT_W){1'b0}}, box_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_count <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      box_count <= pwdata[rbnp_pkg::COUNT_W-1:0];
    end
  end

  rbnp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .entry_valid (entry_valid),
    .entry       (entry),
    .pop         (pop)
  );

  rbnp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .entry_valid (entry_valid),
    .entry       (entry),
    .pop         (pop),
    .box_count   (box_count),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

endmodule

// ===== tb/ray_box_nearest_pick_test.sv =====
// Testbench for the ray box picker: directed and random box writes and picks against a predictor.
`timescale 1ns / 1ps

module ray_box_nearest_pick_test;

  localparam longint UNIT      = 64'sd1 << rbnp_pkg::FRACTION_BITS;
  localparam longint T_OPEN    = 64'sd1 << 62;
  localparam longint DIST_TOP  = 64'sh7FFF_FFFF;
  localparam longint CYCLE_CAP = 30_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  rbnp_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rbnp_pkg::out_item_t out_item;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [rbnp_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ray_box_nearest_pick i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  longint box_lo [rbnp_pkg::BOX_SLOTS][3];
  longint box_hi [rbnp_pkg::BOX_SLOTS][3];
  bit sel_valid;
  logic [rbnp_pkg::SLOT_W-1:0] sel_slot;
  int active_boxes;
  rbnp_pkg::out_item_t picks_due[$];

  int errors;
  int picks_sent;
  int hits_seen;
  int writes_sent;
  int results_seen;
  longint cycles;
  bit sender_gaps;
  int stall_pct;
  int hold_cycles;

  function automatic rbnp_pkg::out_item_t nearest_pick(rbnp_pkg::in_item_t it);
    longint org [3];
    longint dirv [3];
    longint tn, tx, t1, t2, tmp, best;
    bit ok, found;
    int n, slot;
    rbnp_pkg::out_item_t r;
    org[0] = it.origin_or_min_x; org[1] = it.origin_or_min_y; org[2] = it.origin_or_min_z;
    dirv[0] = it.dir_or_max_x; dirv[1] = it.dir_or_max_y; dirv[2] = it.dir_or_max_z;
    n = active_boxes < rbnp_pkg::BOX_SLOTS ? active_boxes : rbnp_pkg::BOX_SLOTS;
    found = 0;
    best = T_OPEN;
    slot = 0;
    for (int i = 0; i < n; i++) begin
      tn = 0;
      tx = T_OPEN;
      ok = 1;
      for (int a = 0; a < 3; a++) begin
        if (!ok) continue;
        if (dirv[a] == 0) begin
          if (org[a] < box_lo[i][a] || org[a] > box_hi[i][a]) ok = 0;
        end else begin
          t1 = ((box_lo[i][a] - org[a]) * UNIT) / dirv[a];
          t2 = ((box_hi[i][a] - org[a]) * UNIT) / dirv[a];
          if (t1 > t2) begin
            tmp = t1; t1 = t2; t2 = tmp;
          end
          if (t1 > tn) tn = t1;
          if (t2 < tx) tx = t2;
          if (tn > tx) ok = 0;
        end
      end
      if (ok && tx < 0) ok = 0;
      if (ok && (!found || tn < best)) begin
        found = 1;
        best = tn;
        slot = i;
      end
    end
    r.hit = found;
    if (found) begin
      r.hit_slot = rbnp_pkg::SLOT_W'(slot);
      r.hit_distance = rbnp_pkg::DIST_W'(best > DIST_TOP ? DIST_TOP : best);
      r.selection_changed = !sel_valid || sel_slot != rbnp_pkg::SLOT_W'(slot);
    end else begin
      r.hit_slot = '0;
      r.hit_distance = '0;
      r.selection_changed = sel_valid;
    end
    sel_valid = found;
    sel_slot = r.hit_slot;
    return r;
  endfunction

  task automatic send_item(rbnp_pkg::in_item_t it);
    int gap;
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    if (it.cmd == rbnp_pkg::CMD_PICK) begin
      picks_due = {picks_due, nearest_pick(it)};
      picks_sent++;
    end else begin
      box_lo[it.box_slot][0] = it.origin_or_min_x;
      box_lo[it.box_slot][1] = it.origin_or_min_y;
      box_lo[it.box_slot][2] = it.origin_or_min_z;
      box_hi[it.box_slot][0] = it.dir_or_max_x;
      box_hi[it.box_slot][1] = it.dir_or_max_y;
      box_hi[it.box_slot][2] = it.dir_or_max_z;
      writes_sent++;
    end
    gap = 0;
    if (sender_gaps) begin
      gap = $urandom_range(0, 99);
      gap = gap < 60 ? 0 : gap < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (picks_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_box_count(int count);
    drop_valid();
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= rbnp_pkg::ADDR_W'(4 * rbnp_pkg::REG_BOX_COUNT);
    pwdata <= 32'(count);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    active_boxes = count;
    @(posedge clk);
  endtask

  function automatic rbnp_pkg::in_item_t make_item(logic cmd, int slot, longint ox,
                                                   longint oy, longint oz, longint dx,
                                                   longint dy, longint dz);
    rbnp_pkg::in_item_t it;
    it.cmd = cmd;
    it.box_slot = rbnp_pkg::SLOT_W'(slot);
    it.origin_or_min_x = rbnp_pkg::VAL_W'(ox);
    it.origin_or_min_y = rbnp_pkg::VAL_W'(oy);
    it.origin_or_min_z = rbnp_pkg::VAL_W'(oz);
    it.dir_or_max_x = rbnp_pkg::VAL_W'(dx);
    it.dir_or_max_y = rbnp_pkg::VAL_W'(dy);
    it.dir_or_max_z = rbnp_pkg::VAL_W'(dz);
    return it;
  endfunction

  task automatic test_directed();
    longint lo_min, hi_max;
    lo_min = -(64'sd1 << 31);
    hi_max = (64'sd1 << 31) - 1;
    send_item(make_item(rbnp_pkg::CMD_PICK, 15, 0, 0, 0, UNIT, 0, 0));
    for (int i = 0; i < rbnp_pkg::BOX_SLOTS; i++)
      send_item(make_item(rbnp_pkg::CMD_WRITE, i, (4 + 4 * i) * UNIT, -UNIT, -UNIT,
                          (5 + 4 * i) * UNIT, UNIT, UNIT));
    set_box_count(rbnp_pkg::BOX_SLOTS);
    send_item(make_item(rbnp_pkg::CMD_PICK, 0, 0, 0, 0, UNIT, 0, 0));
    send_item(make_item(rbnp_pkg::CMD_PICK, 0, 0, 0, 0, UNIT, 0, 0));
    send_item(make_item(rbnp_pkg::CMD_PICK, 0, 200 * UNIT, 0, 0, UNIT, 0, 0));
    send_item(make_item(rbnp_pkg::CMD_PICK, 0, 200 * UNIT, 0, 0, -UNIT, 0, 0));
    send_item(make_item(rbnp_pkg::CMD_PICK, 0, 0, 5 * UNIT, 0, UNIT, 0, 0));
    send_item(make_item(rbnp_pkg::CMD_PICK, 0, 16 * UNIT + UNIT / 2, 0, 0, UNIT,
                        UNIT / 8, 0));
    send_item(make_item(rbnp_pkg::CMD_PICK, 0, 0, 0, 0, 1, 0, 0));
    send_item(make_item(rbnp_pkg::CMD_WRITE, 7, 8 * UNIT, -UNIT, -UNIT, 9 * UNIT, UNIT,
                        UNIT));
    send_item(make_item(rbnp_pkg::CMD_PICK, 0, 6 * UNIT, 0, 0, UNIT, 0, 0));
    send_item(make_item(rbnp_pkg::CMD_WRITE, 0, 5 * UNIT, -UNIT, -UNIT, 4 * UNIT, UNIT,
                        UNIT));
    send_item(make_item(rbnp_pkg::CMD_PICK, 0, 0, 0, 0, UNIT, 0, 0));
    send_item(make_item(rbnp_pkg::CMD_PICK, 0, 4 * UNIT + UNIT / 2, -5 * UNIT, 0, 0,
                        UNIT, 0));
    send_item(make_item(rbnp_pkg::CMD_WRITE, 15, lo_min, lo_min, lo_min, hi_max, hi_max,
                        hi_max));
    send_item(make_item(rbnp_pkg::CMD_PICK, 15, lo_min, lo_min, lo_min, hi_max, hi_max,
                        hi_max));
    send_item(make_item(rbnp_pkg::CMD_PICK, 0, hi_max, hi_max, hi_max, lo_min, lo_min,
                        lo_min));
    send_item(make_item(rbnp_pkg::CMD_PICK, 0, 0, 0, 0, lo_min, 0, 0));
    set_box_count(1);
    send_item(make_item(rbnp_pkg::CMD_PICK, 0, 0, 0, 0, UNIT, 0, 0));
    set_box_count(0);
    send_item(make_item(rbnp_pkg::CMD_PICK, 0, 0, 0, 0, UNIT, 0, 0));
  endtask

  task automatic send_random(int count);
    rbnp_pkg::in_item_t it;
    longint c, h, org, dirv;
    int s, sh, flat;
    for (int k = 0; k < count; k++) begin
      it = '0;
      it.box_slot = rbnp_pkg::SLOT_W'($urandom_range(0, rbnp_pkg::BOX_SLOTS - 1));
      if ($urandom_range(0, 99) < 45) begin
        it.cmd = rbnp_pkg::CMD_PICK;
        if (active_boxes > 0 && $urandom_range(0, 99) < 80) begin
          s = $urandom_range(0, active_boxes - 1);
          sh = $urandom_range(0, 6);
          flat = $urandom_range(0, 99) < 20 ? $urandom_range(0, 2) : 3;
          for (int a = 0; a < 3; a++) begin
            c = (box_lo[s][a] + box_hi[s][a]) >>> 1;
            org = c + longint'($urandom_range(0, 256 * UNIT)) - 128 * UNIT;
            dirv = (c - org) >>> sh;
            if (a == flat) begin
              org = c;
              dirv = 0;
            end
            if (a == 0) begin
              it.origin_or_min_x = rbnp_pkg::VAL_W'(org);
              it.dir_or_max_x = rbnp_pkg::VAL_W'(dirv);
            end else if (a == 1) begin
              it.origin_or_min_y = rbnp_pkg::VAL_W'(org);
              it.dir_or_max_y = rbnp_pkg::VAL_W'(dirv);
            end else begin
              it.origin_or_min_z = rbnp_pkg::VAL_W'(org);
              it.dir_or_max_z = rbnp_pkg::VAL_W'(dirv);
            end
          end
        end else begin
          it.origin_or_min_x = $urandom; it.origin_or_min_y = $urandom;
          it.origin_or_min_z = $urandom;
          it.dir_or_max_x = $urandom_range(0, 3) == 0 ? '0 : rbnp_pkg::VAL_W'($urandom);
          it.dir_or_max_y = $urandom_range(0, 3) == 0 ? '0 : rbnp_pkg::VAL_W'($urandom);
          it.dir_or_max_z = $urandom_range(0, 3) == 0 ? '0 : rbnp_pkg::VAL_W'($urandom);
        end
      end else begin
        it.cmd = rbnp_pkg::CMD_WRITE;
        if ($urandom_range(0, 99) < 85) begin
          for (int a = 0; a < 3; a++) begin
            c = longint'($urandom_range(0, 128 * UNIT)) - 64 * UNIT;
            h = longint'($urandom_range(UNIT / 4, 8 * UNIT));
            if ($urandom_range(0, 19) == 0) h = -h;
            if (a == 0) begin
              it.origin_or_min_x = rbnp_pkg::VAL_W'(c - h);
              it.dir_or_max_x = rbnp_pkg::VAL_W'(c + h);
            end else if (a == 1) begin
              it.origin_or_min_y = rbnp_pkg::VAL_W'(c - h);
              it.dir_or_max_y = rbnp_pkg::VAL_W'(c + h);
            end else begin
              it.origin_or_min_z = rbnp_pkg::VAL_W'(c - h);
              it.dir_or_max_z = rbnp_pkg::VAL_W'(c + h);
            end
          end
        end else begin
          it.origin_or_min_x = $urandom; it.origin_or_min_y = $urandom;
          it.origin_or_min_z = $urandom; it.dir_or_max_x = $urandom;
          it.dir_or_max_y = $urandom; it.dir_or_max_z = $urandom;
        end
      end
      send_item(it);
    end
  endtask

  task automatic test_backpressure();
    set_box_count(2);
    hold_cycles = 4000;
    @(posedge clk);
    for (int k = 0; k < 8; k++)
      send_item(make_item(rbnp_pkg::CMD_PICK, k, 0, 0, 0, UNIT, 0, 0));
  endtask

  task automatic test_random_phases();
    int counts [14] = '{16, 1, 3, 2, 8, 4, 1, 5, 2, 3, 16, 6, 0, 2};
    for (int ph = 0; ph < 14; ph++) begin
      set_box_count(counts[ph]);
      sender_gaps = (ph % 3) != 2;
      stall_pct = sender_gaps ? 30 : 0;
      send_random(counts[ph] >= 8 ? 60 : 150);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else begin
      if ($urandom_range(0, 299) == 0) hold_cycles = $urandom_range(20, 100);
      out_stall <= $urandom_range(0, 99) < stall_pct;
    end
  end

  always @(posedge clk) begin
    rbnp_pkg::out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (picks_due.size() == 0) begin
        $display("%0t: result with none pending: %p", $time, out_item);
        errors++;
      end else begin
        want = picks_due.pop_front();
        if (out_item.hit) hits_seen++;
        if (out_item.hit !== want.hit) begin
          $display("%0t: hit expected %0d got %0d", $time, want.hit, out_item.hit);
          errors++;
        end
        if (out_item.hit_slot !== want.hit_slot) begin
          $display("%0t: hit_slot expected %0d got %0d", $time, want.hit_slot,
                   out_item.hit_slot);
          errors++;
        end
        if (out_item.hit_distance !== want.hit_distance) begin
          $display("%0t: hit_distance expected %0h got %0h", $time, want.hit_distance,
                   out_item.hit_distance);
          errors++;
        end
        if (out_item.selection_changed !== want.selection_changed) begin
          $display("%0t: selection_changed expected %0d got %0d", $time,
                   want.selection_changed, out_item.selection_changed);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("ray_box_nearest_pick_test: errors");
      $finish;
    end
  end

  initial begin
    errors = 0; picks_sent = 0; hits_seen = 0; writes_sent = 0; results_seen = 0;
    cycles = 0; hold_cycles = 0; stall_pct = 20; sender_gaps = 1;
    sel_valid = 0; sel_slot = '0; active_boxes = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_phases();
    drop_valid();
    while (picks_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Covered %0d box writes and %0d picks (%0d results, %0d hits), counts 0 to 16,",
             writes_sent, picks_sent, results_seen, hits_seen);
    $display("with random gaps, output stalls and one long hold-off; %0d mismatches.",
             errors);
    if (errors == 0) begin
      $display("ray_box_nearest_pick_test: clean");
    end else begin
      $display("ray_box_nearest_pick_test: errors");
    end
    $finish;
  end

endmodule
